FILE: design/polynomial_kernel_evaluate_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the polynomial kernel evaluator
// Each macro expands to a concurrent assertion clocked on clk and disabled
// while rst is high; with SYNTH defined they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_KERNEL_EVALUATE_ASSERT_SVH
`define POLYNOMIAL_KERNEL_EVALUATE_ASSERT_SVH

`ifndef SYNTH

`define PKE_ASSERT_HOLDS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define PKE_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define PKE_ASSERT_HOLDS(name, expr, msg)

`define PKE_ASSERT_IMPLIES(name, ante, cons, msg)

`endif

`endif

FILE: design/pke_pkg.sv
// ----------------------------------------------------------------------------
// Polynomial kernel evaluator package
// Shared widths, constants, the register map and the record that travels
// down the cell chain.
// ----------------------------------------------------------------------------
package pke_pkg;

  localparam int DEF_MAX_TERMS = 4;
  localparam int DEF_MAX_POWER = 8;
  localparam int FRAC_BITS     = 16;

  localparam int IN_W      = 21;
  localparam int DATA_W    = 32;
  localparam int WORK_BITS = 30;
  localparam int Q_W       = WORK_BITS + 1;
  localparam int SQ_W      = 2 * IN_W;
  localparam int SQ_SHIFT  = 2 * FRAC_BITS - WORK_BITS;
  localparam int TERM_W    = DATA_W + Q_W;
  localparam int SUM_W     = DATA_W + 4;
  localparam int CLAMP_W   = DATA_W + 2;
  localparam int NUM_COEFS = 4;
  localparam int REG_IDX_W = 3;

  localparam logic [Q_W-1:0] Q_UNITY = {1'b1, {WORK_BITS{1'b0}}};
  localparam logic signed [DATA_W-1:0] U_ONE = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [TERM_W-1:0] TERM_HALF = TERM_W'(1) << (WORK_BITS - 1);

  localparam logic [3:0]        RST_POWER_S  = 4'd1;
  localparam logic [2:0]        RST_TERMS    = 3'd1;
  localparam logic [DATA_W-1:0] RST_SCALE    = 32'd12582912;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_POWER_S    = 3'd0,
    REG_TERM_COUNT = 3'd1,
    REG_SCALE      = 3'd2,
    REG_COEF_ZERO  = 3'd3,
    REG_COEF_ONE   = 3'd4,
    REG_COEF_TWO   = 3'd5,
    REG_COEF_THREE = 3'd6
  } pke_reg_t;

  // One point in flight: running power of (1-u^2), running even power of u,
  // polynomial partial sum and the coefficient product still to be added.
  typedef struct packed {
    logic                     valid;
    logic                     in_dom;
    logic [Q_W-1:0]           t;
    logic [Q_W-1:0]           u2;
    logic [Q_W-1:0]           p;
    logic [Q_W-1:0]           v;
    logic signed [SUM_W-1:0]  sum;
    logic signed [TERM_W-1:0] term;
  } pke_flow_t;

  // Signed Q30 product rounded half up to Q0 of the other operand's format.
  function automatic logic signed [DATA_W-1:0] round_q30(input logic signed [TERM_W-1:0] x);
    logic signed [TERM_W-1:0] y;
    y = x + TERM_HALF;
    return DATA_W'(y >>> WORK_BITS);
  endfunction

endpackage

FILE: design/pke_front.sv
// ----------------------------------------------------------------------------
// Polynomial kernel front end
// Checks the domain, squares |u| and converts u^2 to Q30, then seeds the
// record that enters the cell chain.
// ----------------------------------------------------------------------------
module pke_front import pke_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic signed [IN_W-1:0] point_u,
  output pke_flow_t              flow_out
);

  logic signed [DATA_W-1:0] u_ext;
  logic                     in_range;
  logic [IN_W-1:0]          mag_next;

  logic                     valid1;
  logic                     in_dom1;
  logic [IN_W-1:0]          mag1;
  logic                     valid2;
  logic                     in_dom2;
  logic [SQ_W-1:0]          sq2;
  logic [Q_W-1:0]           u2_q30;
  pke_flow_t                flow_next;

  always_comb begin
    u_ext    = DATA_W'(point_u);
    in_range = (u_ext <= U_ONE) && (u_ext >= -U_ONE);
    mag_next = point_u[IN_W-1] ? IN_W'(-u_ext) : IN_W'(u_ext);
  end

  generate
    if (SQ_SHIFT > 0) begin : g_round
      logic [SQ_W-1:0] sq_rnd;
      assign sq_rnd = sq2 + (SQ_W'(1) << (SQ_SHIFT - 1));
      assign u2_q30 = Q_W'(sq_rnd >> SQ_SHIFT);
    end else if (SQ_SHIFT == 0) begin : g_exact
      assign u2_q30 = Q_W'(sq2);
    end else begin : g_widen
      assign u2_q30 = Q_W'(sq2 << (-SQ_SHIFT));
    end
  endgenerate

  always_comb begin
    flow_next        = '0;
    flow_next.valid  = valid2;
    flow_next.in_dom = in_dom2;
    flow_next.u2     = u2_q30;
    flow_next.t      = Q_UNITY - u2_q30;
    flow_next.p      = Q_UNITY;
    flow_next.v      = Q_UNITY;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1         <= 1'b0;
      valid2         <= 1'b0;
      flow_out.valid <= 1'b0;
    end else begin
      valid1         <= accept;
      valid2         <= valid1;
      flow_out.valid <= flow_next.valid;
    end
    in_dom1 <= in_range;
    mag1    <= mag_next;
    in_dom2 <= in_dom1;
    sq2     <= SQ_W'(mag1) * SQ_W'(mag1);
    flow_out.in_dom <= flow_next.in_dom;
    flow_out.t      <= flow_next.t;
    flow_out.u2     <= flow_next.u2;
    flow_out.p      <= flow_next.p;
    flow_out.v      <= flow_next.v;
    flow_out.sum    <= flow_next.sum;
    flow_out.term   <= flow_next.term;
  end

endmodule

FILE: design/pke_cell.sv
// ----------------------------------------------------------------------------
// Polynomial kernel chain cell
// One step of both products: multiplies the running (1-u^2) power by t when
// enabled, advances the even power of u and accumulates one coefficient term.
// ----------------------------------------------------------------------------
module pke_cell import pke_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  pke_flow_t                flow_in,
  input  logic                     pwr_en,
  input  logic signed [DATA_W-1:0] coef,
  output pke_flow_t                flow_out
);

  logic [2*Q_W-1:0]         p_rnd;
  logic [2*Q_W-1:0]         v_rnd;
  logic signed [TERM_W-1:0] term_prod;
  pke_flow_t                flow_next;

  always_comb begin
    p_rnd     = (2*Q_W)'(flow_in.p) * (2*Q_W)'(flow_in.t)
                + ((2*Q_W)'(1) << (WORK_BITS - 1));
    v_rnd     = (2*Q_W)'(flow_in.v) * (2*Q_W)'(flow_in.u2)
                + ((2*Q_W)'(1) << (WORK_BITS - 1));
    term_prod = coef * $signed({1'b0, flow_in.v});

    flow_next      = flow_in;
    flow_next.p    = pwr_en ? p_rnd[WORK_BITS +: Q_W] : flow_in.p;
    flow_next.v    = v_rnd[WORK_BITS +: Q_W];
    flow_next.term = term_prod;
    // The product registered by the previous cell is folded in here.
    flow_next.sum  = flow_in.sum + SUM_W'(round_q30(flow_in.term));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_out <= '0;
    end else begin
      flow_out <= flow_next;
    end
  end

endmodule

FILE: design/pke_back.sv
// ----------------------------------------------------------------------------
// Polynomial kernel back end
// Applies the scale multiplier, multiplies by the clamped polynomial sum in
// two partial products, rounds to Q8.24 and saturates; zero outside the domain.
// ----------------------------------------------------------------------------
module pke_back import pke_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  pke_flow_t                flow_in,
  input  logic signed [DATA_W-1:0] scale,
  input  logic                     poly_on,
  output logic                     done,
  output logic signed [DATA_W-1:0] kernel_value,
  output logic                     saturated
);

  localparam int SPLIT  = 16;
  localparam int HI_W   = CLAMP_W - SPLIT;
  localparam int PLO_W  = DATA_W + SPLIT + 1;
  localparam int PHI_W  = DATA_W + HI_W;
  localparam int TOT_W  = PHI_W + SPLIT;
  localparam int OUT_SH = 24;
  localparam int RES_W  = TOT_W - OUT_SH;

  localparam logic signed [SUM_W-1:0] SUM_LIM = SUM_W'(64'h0000_0000_FFFF_FFFF);
  localparam logic signed [PLO_W-1:0] RND_OUT = PLO_W'(1) << (OUT_SH - 1);
  localparam logic signed [RES_W-1:0] RES_MAX = RES_W'(32'sh7FFF_FFFF);
  localparam logic signed [RES_W-1:0] RES_MIN = RES_W'(32'sh8000_0000);

  logic                      valid1, valid2, valid3;
  logic                      in_dom1, in_dom2, in_dom3;
  logic signed [TERM_W-1:0]  mp1;
  logic signed [CLAMP_W-1:0] sum1, sum2;
  logic signed [DATA_W-1:0]  a2, a3;
  logic signed [PLO_W-1:0]   plo3;
  logic signed [PHI_W-1:0]   phi3;

  logic signed [SUM_W-1:0]   sum_full;
  logic signed [CLAMP_W-1:0] sum_clamp;
  logic signed [TOT_W-1:0]   total;
  logic signed [RES_W-1:0]   res;
  logic signed [DATA_W-1:0]  value_next;
  logic                      sat_next;

  always_comb begin
    sum_full = flow_in.sum + SUM_W'(round_q30(flow_in.term));
    if (sum_full > SUM_LIM) begin
      sum_clamp = CLAMP_W'(SUM_LIM);
    end else if (sum_full < -SUM_LIM) begin
      sum_clamp = CLAMP_W'(-SUM_LIM);
    end else begin
      sum_clamp = CLAMP_W'(sum_full);
    end
  end

  always_comb begin
    total = (TOT_W'(phi3) <<< SPLIT) + TOT_W'(plo3);
    res   = RES_W'(total >>> OUT_SH);
    value_next = '0;
    sat_next   = 1'b0;
    if (!in_dom3) begin
      value_next = '0;
    end else if (!poly_on) begin
      value_next = a3;
    end else if (res > RES_MAX) begin
      value_next = DATA_W'(RES_MAX);
      sat_next   = 1'b1;
    end else if (res < RES_MIN) begin
      value_next = DATA_W'(RES_MIN);
      sat_next   = 1'b1;
    end else begin
      value_next = DATA_W'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
      valid2 <= 1'b0;
      valid3 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid1 <= flow_in.valid;
      valid2 <= valid1;
      valid3 <= valid2;
      done   <= valid3;
    end
    in_dom1 <= flow_in.in_dom;
    mp1     <= scale * $signed({1'b0, flow_in.p});
    sum1    <= sum_clamp;

    in_dom2 <= in_dom1;
    a2      <= round_q30(mp1);
    sum2    <= sum1;

    // The sum is split so that neither partial product exceeds 32 by 18 bits.
    in_dom3 <= in_dom2;
    a3      <= a2;
    plo3    <= a2 * $signed({1'b0, sum2[SPLIT-1:0]}) + RND_OUT;
    phi3    <= a2 * $signed(sum2[CLAMP_W-1:SPLIT]);

    kernel_value <= value_next;
    saturated    <= sat_next;
  end

endmodule

FILE: design/polynomial_kernel_evaluate.sv
// ----------------------------------------------------------------------------
// Polynomial kernel evaluator (uniform / Epanechnikov / biweight family)
// A request passes the front end, the cell chain and the back end registers
// before its done strobe; the depth of the cell chain sets the delay.
// Throughput: one request per cycle; busy is only high during reset.
// Reset clears every in-flight request and loads the register defaults.
// Each result is shown for exactly one cycle with done; it cannot be stalled.
// ----------------------------------------------------------------------------
`include "polynomial_kernel_evaluate_assert.svh"

module polynomial_kernel_evaluate import pke_pkg::*; #(
  parameter int MAX_TERMS = DEF_MAX_TERMS,
  parameter int MAX_POWER = DEF_MAX_POWER
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [IN_W-1:0]   point_u,
  input  logic                     write_enable,
  input  logic [REG_IDX_W-1:0]     write_index,
  input  logic [DATA_W-1:0]        write_data,
  output logic                     done,
  output logic signed [DATA_W-1:0] kernel_value,
  output logic                     saturated
);

  localparam int N_CELLS = (MAX_POWER > MAX_TERMS) ? MAX_POWER : MAX_TERMS;

  logic [3:0]               power_s;
  logic [2:0]               term_count;
  logic signed [DATA_W-1:0] scale_multiplier;
  logic signed [DATA_W-1:0] coef_regs [NUM_COEFS];

  logic                     accept;
  logic                     poly_on;
  logic [N_CELLS-1:0]       pwr_en;
  logic signed [DATA_W-1:0] cell_coef [N_CELLS];
  pke_flow_t                chain [N_CELLS+1];

  assign busy    = rst;
  assign accept  = start && !busy;
  assign poly_on = (int'(term_count) > 1) && (MAX_TERMS > 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      power_s          <= RST_POWER_S;
      term_count       <= RST_TERMS;
      scale_multiplier <= RST_SCALE;
      for (int k = 0; k < NUM_COEFS; k++) begin
        coef_regs[k] <= '0;
      end
    end else if (write_enable) begin
      unique case (write_index)
        REG_POWER_S:    power_s          <= write_data[3:0];
        REG_TERM_COUNT: term_count       <= write_data[2:0];
        REG_SCALE:      scale_multiplier <= write_data;
        REG_COEF_ZERO:  coef_regs[0]     <= write_data;
        REG_COEF_ONE:   coef_regs[1]     <= write_data;
        REG_COEF_TWO:   coef_regs[2]     <= write_data;
        REG_COEF_THREE: coef_regs[3]     <= write_data;
        default: ;
      endcase
    end
  end

  pke_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .point_u  (point_u),
    .flow_out (chain[0])
  );

  generate
    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
      assign pwr_en[i] = (int'(power_s) > i) && (i < MAX_POWER);
      if (i < NUM_COEFS) begin : g_coef
        assign cell_coef[i] = ((int'(term_count) > i) && (i < MAX_TERMS)) ?
                              coef_regs[i] : '0;
      end else begin : g_nocoef
        // Terms past the fourth have no coefficient register.
        assign cell_coef[i] = '0;
      end

      pke_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .flow_in  (chain[i]),
        .pwr_en   (pwr_en[i]),
        .coef     (cell_coef[i]),
        .flow_out (chain[i+1])
      );
    end
  endgenerate

  pke_back u_back (
    .clk          (clk),
    .rst          (rst),
    .flow_in      (chain[N_CELLS]),
    .scale        (scale_multiplier),
    .poly_on      (poly_on),
    .done         (done),
    .kernel_value (kernel_value),
    .saturated    (saturated)
  );

  `PKE_ASSERT_HOLDS(a_done_has_request,
    !done || $past(accept, N_CELLS + 7), "done strobe without a matching request")

  `PKE_ASSERT_IMPLIES(a_sat_is_clipped, done && saturated,
    kernel_value == 32'sh7FFF_FFFF || kernel_value == 32'sh8000_0000,
    "saturated result is not at a range limit")

  `PKE_ASSERT_IMPLIES(a_outside_is_zero,
    done && $past(accept && ((DATA_W'(point_u) > U_ONE) || (DATA_W'(point_u) < -U_ONE)),
                  N_CELLS + 7),
    kernel_value == '0 && !saturated, "point outside the domain gave a nonzero result")

endmodule
